@@ rtl/bpe_pkg.sv @@
package bpe_pkg;

	// Grid size: the patch has PATCH_ORDER x PATCH_ORDER control points
	localparam int PATCH_ORDER = 4;
	localparam int IDX_W       = (PATCH_ORDER > 2) ? $clog2(PATCH_ORDER) : 1;
	localparam int LVL_W       = (PATCH_ORDER > 2) ? $clog2(PATCH_ORDER - 1) : 1;

	// Number formats
	localparam int COORD_W = 24;
	localparam int PARAM_W = 17;
	localparam int FRAC_W  = 16;
	localparam int PROD_W  = COORD_W + PARAM_W + 2;

	localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1 << FRAC_W);

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic [PARAM_W-1:0]        param_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		prod_t x;
		prod_t y;
		prod_t z;
	} prod_pt_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_MUL,
		CELL_ADD
	} cell_op_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		cell_op_t         op;
		logic             sel_ext;
		logic [IDX_W-1:0] rd_idx;
		param_t           t;
	} cell_ctrl_t;

	// Control point write into one cell's column store
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		point_t           pt;
	} cell_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MUL,
		ST_ADD,
		ST_FINISH
	} seq_state_t;

	// Parameters above 1.0 saturate to 1.0
	function automatic param_t clamp_param(param_t p);
		return (p > PARAM_ONE) ? PARAM_ONE : p;
	endfunction

	// First half of a lerp: (b - a) * t
	function automatic prod_t lerp_mul(coord_t a, coord_t b, param_t t);
		logic signed [COORD_W:0] diff;
		logic signed [PARAM_W:0] ts;
		diff = {b[COORD_W-1], b} - {a[COORD_W-1], a};
		ts   = {1'b0, t};
		return diff * ts;
	endfunction

	// Second half: a + floor(prod / 2^16); the result stays between a and b
	function automatic coord_t lerp_add(coord_t a, prod_t p);
		prod_t sh;
		sh = p >>> FRAC_W;
		return a + sh[COORD_W-1:0];
	endfunction

endpackage

@@ rtl/bezier_patch_evaluate.sv @@
// Bicubic Bezier patch evaluator. A load transaction (cmd 0) writes one control
// point into the grid and does not stall the input. An evaluate transaction
// (cmd 1) holds the input stalled until its surface point enters the output
// register. With N as PATCH_ORDER, a row of N cells, one per grid column,
// reduces each grid row at u and then the column of row results at v, and each
// of the N-1 de Casteljau levels takes a multiply step and an add step in every
// cell. The sequencer waits in its finish state for as long as the previous
// surface point is still stalled in the output register.
// The surface point then sits in an output register; the next transaction is
// accepted while it waits to be taken. All control points must be loaded
// before the first evaluate. Parameters above 1.0 act as 1.0.
module bezier_patch_evaluate (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           cmd,
	input  logic [1:0]     row,
	input  logic [1:0]     col,
	input  logic signed [23:0] px,
	input  logic signed [23:0] py,
	input  logic signed [23:0] pz,
	input  logic [16:0]    u_param,
	input  logic [16:0]    v_param,
	output logic           out_valid,
	input  logic           out_stall,
	output logic signed [23:0] sx,
	output logic signed [23:0] sy,
	output logic signed [23:0] sz
);
	import bpe_pkg::*;

	seq_state_t       state_q, state_d;
	logic [IDX_W-1:0] row_q;
	logic [LVL_W-1:0] lvl_q;
	logic             col_pass_q;
	param_t           u_q, v_q;
	point_t           rres_q [PATCH_ORDER-1];
	point_t           out_pt_q;
	logic             out_valid_q;

	logic             in_acc;
	logic             eval_acc;
	logic             last_lvl;
	logic             push_row;
	logic             out_load;
	cell_ctrl_t       ctrl;
	point_t           cell_pt [PATCH_ORDER];
	point_t           ext_pt  [PATCH_ORDER];
	cell_wr_t         cell_wr [PATCH_ORDER];
	point_t           in_pt;

	assign in_acc   = in_valid && !in_stall;
	assign eval_acc = in_acc && (cmd == CMD_EVAL);
	assign in_stall = (state_q != ST_IDLE);
	assign last_lvl = (lvl_q == LVL_W'(PATCH_ORDER - 2));
	assign push_row = (state_q == ST_FETCH) && !col_pass_q && (row_q != '0);
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign in_pt    = '{x: px, y: py, z: pz};

	// Sequencer: next state and cell command
	always_comb begin
		state_d      = state_q;
		ctrl.op      = CELL_HOLD;
		ctrl.sel_ext = col_pass_q;
		ctrl.rd_idx  = row_q;
		ctrl.t       = col_pass_q ? v_q : u_q;
		case (state_q)
			ST_IDLE: begin
				if (eval_acc) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				ctrl.op = CELL_LOAD;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				ctrl.op = CELL_MUL;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				ctrl.op = CELL_ADD;
				if (!last_lvl) begin
					state_d = ST_MUL;
				end else if (col_pass_q) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_FETCH;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Row and level counters, pass flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			lvl_q      <= '0;
			col_pass_q <= 1'b0;
		end else begin
			if (eval_acc) begin
				row_q      <= '0;
				col_pass_q <= 1'b0;
			end
			if (state_q == ST_FETCH) begin
				lvl_q <= '0;
			end
			if (state_q == ST_ADD) begin
				if (!last_lvl) begin
					lvl_q <= lvl_q + 1'b1;
				end else if (!col_pass_q) begin
					if (row_q == IDX_W'(PATCH_ORDER - 1)) begin
						col_pass_q <= 1'b1;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
			end
		end
	end

	// Interpolation parameters for the transaction in flight
	always_ff @(posedge clk) begin
		if (eval_acc) begin
			u_q <= clamp_param(u_param);
			v_q <= clamp_param(v_param);
		end
	end

	// Row results shift in from the top; after N-1 rows entry i holds row i
	always_ff @(posedge clk) begin
		if (push_row) begin
			rres_q[PATCH_ORDER-2] <= cell_pt[0];
			for (int i = 0; i < PATCH_ORDER - 2; i++) begin
				rres_q[i] <= rres_q[i+1];
			end
		end
	end

	// Chain of cells, cell i holds grid column i
	for (genvar i = 0; i < PATCH_ORDER; i++) begin : g_cell
		assign cell_wr[i].en  = in_acc && (cmd == CMD_LOAD) && (int'(col) == i) &&
		                        (int'(row) < PATCH_ORDER);
		assign cell_wr[i].idx = IDX_W'(row);
		assign cell_wr[i].pt  = in_pt;

		if (i < PATCH_ORDER - 1) begin : g_mid
			assign ext_pt[i] = rres_q[i];
			bpe_cell u_cell (
				.clk    (clk),
				.ctrl   (ctrl),
				.wr     (cell_wr[i]),
				.ext_pt (ext_pt[i]),
				.nbr_pt (cell_pt[i+1]),
				.pt     (cell_pt[i])
			);
		end else begin : g_last
			// last row result still sits in cell 0 when the column pass loads
			assign ext_pt[i] = cell_pt[0];
			bpe_cell u_cell (
				.clk    (clk),
				.ctrl   (ctrl),
				.wr     (cell_wr[i]),
				.ext_pt (ext_pt[i]),
				.nbr_pt (cell_pt[i]),
				.pt     (cell_pt[i])
			);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pt_q <= cell_pt[0];
		end
	end

	assign out_valid = out_valid_q;
	assign sx        = out_pt_q.x;
	assign sy        = out_pt_q.y;
	assign sz        = out_pt_q.z;

	// A result appears only after the column pass has finished
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result issued outside finish state");

	// A pending result that is stalled is never overwritten
	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) && out_valid_q && out_stall |=>
		(state_q == ST_FINISH) && $stable(out_pt_q))
		else $error("pending result overwritten");

	// An accepted evaluate starts the row pass at row zero
	a_eval_starts: assert property (@(posedge clk) disable iff (!arst_n)
		eval_acc |=> (state_q == ST_FETCH) && (row_q == '0) && !col_pass_q)
		else $error("evaluate did not start at row zero");

	// The column pass begins only after the last grid row
	a_col_after_rows: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(col_pass_q) |-> (row_q == IDX_W'(PATCH_ORDER - 1)))
		else $error("column pass started early");

endmodule

@@ rtl/bpe_cell.sv @@
module bpe_cell (
	input  logic                clk,
	input  bpe_pkg::cell_ctrl_t ctrl,
	input  bpe_pkg::cell_wr_t   wr,
	input  bpe_pkg::point_t     ext_pt,
	input  bpe_pkg::point_t     nbr_pt,
	output bpe_pkg::point_t     pt
);
	import bpe_pkg::*;

	// One grid column: entry r is the control point of row r
	point_t   store_q [PATCH_ORDER];
	point_t   pt_q;
	prod_pt_t prod_q;

	// Column store write
	always_ff @(posedge clk) begin
		if (wr.en) begin
			store_q[wr.idx] <= wr.pt;
		end
	end

	// Working point: load, then alternate multiply and add with right neighbor
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_LOAD: begin
				pt_q <= ctrl.sel_ext ? ext_pt : store_q[ctrl.rd_idx];
			end
			CELL_MUL: begin
				prod_q.x <= lerp_mul(pt_q.x, nbr_pt.x, ctrl.t);
				prod_q.y <= lerp_mul(pt_q.y, nbr_pt.y, ctrl.t);
				prod_q.z <= lerp_mul(pt_q.z, nbr_pt.z, ctrl.t);
			end
			CELL_ADD: begin
				pt_q.x <= lerp_add(pt_q.x, prod_q.x);
				pt_q.y <= lerp_add(pt_q.y, prod_q.y);
				pt_q.z <= lerp_add(pt_q.z, prod_q.z);
			end
			default: begin
			end
		endcase
	end

	assign pt = pt_q;

endmodule
